// ===== rtl/nfsp_pkg.sv =====
// Package for the nibble frequency string packer: modes, code kinds,
// result and queue-push types shared by the top level and its output queue.
// No dependencies.
package nfsp_pkg;

  // Item modes (carried on in_tuser)
  localparam logic [1:0] MODE_LOAD   = 2'd0;
  localparam logic [1:0] MODE_ENCODE = 2'd1;
  localparam logic [1:0] MODE_END    = 2'd2;

  // Code kinds stored in the table
  localparam logic [1:0] KIND_NONE  = 2'd0;
  localparam logic [1:0] KIND_ONE   = 2'd1;
  localparam logic [1:0] KIND_THREE = 2'd2;

  localparam logic [3:0] ESCAPE_NIBBLE = 4'hF;

  // Output queue geometry
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  // Table entry: kind in the top two bits, code value below
  typedef struct packed {
    logic [1:0] kind;
    logic [6:0] value;
  } entry_t;

  // One result item
  typedef struct packed {
    logic [7:0] out_byte;
    logic       string_done;
    logic       unmapped_error;
  } res_t;

  // Results handed to the output queue in one cycle (0, 1 or 2)
  typedef struct packed {
    logic [1:0] cnt;
    res_t       r0;
    res_t       r1;
  } push_t;

endpackage

// ===== rtl/nfsp_out_fifo.sv =====
// Output queue of the packer: takes up to two results a cycle, drives the
// result stream from its head entry. Depends on nfsp_pkg.
module nfsp_out_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  nfsp_pkg::push_t push,
  output logic           room,        // space for two more results
  output logic           out_tvalid,
  input  logic           out_tready,
  output nfsp_pkg::res_t head
);

  nfsp_pkg::res_t                 mem_r [nfsp_pkg::QDEPTH];
  logic [nfsp_pkg::QPTR_W-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [nfsp_pkg::QPTR_W-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [nfsp_pkg::QCNT_W-1:0]    count_r, count_nxt;
  logic                           pop;

  assign out_tvalid = (count_r != '0);
  assign head       = mem_r[rd_ptr_r];
  assign pop        = out_tvalid && out_tready;
  assign room       = (count_r <= nfsp_pkg::QCNT_W'(nfsp_pkg::QDEPTH - 2));

  // Pointer and fill-level bookkeeping
  always_comb begin
    wr_ptr_nxt = wr_ptr_r + nfsp_pkg::QPTR_W'(push.cnt);
    rd_ptr_nxt = rd_ptr_r + nfsp_pkg::QPTR_W'(pop);
    count_nxt  = count_r + nfsp_pkg::QCNT_W'(push.cnt) - nfsp_pkg::QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage: first result at the write pointer, second one after it
  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) begin
      mem_r[wr_ptr_r] <= push.r0;
    end
    if (push.cnt == 2'd2) begin
      mem_r[wr_ptr_r + nfsp_pkg::QPTR_W'(1)] <= push.r1;
    end
  end

endmodule

// ===== rtl/nibble_frequency_string_packer.sv =====
// Top level of the nibble frequency string packer: code table, nibble
// packing stage and output queue. Depends on nfsp_pkg and nfsp_out_fifo.
//
// Takes one item per clock while in_tready is high. An item is registered
// together with its code table read on the cycle it is accepted. When the
// four-entry output queue has room for two results, the stage register is
// packed and its zero, one or two result bytes are written to the queue,
// whose fill count then raises out_tvalid.
// in_tready drops only while that queue lacks space for two results, so
// sustained input is bounded by the output rate in results: items that yield
// two bytes (three-nibble codes in a high nibble, string ends with a nonzero
// pending nibble) take two queue entries. The table holds CHARSET_SIZE
// entries with one valid flop each, cleared by reset, so no clearing pass is
// needed.
module nibble_frequency_string_packer #(
  parameter int unsigned CHARSET_SIZE = 128
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [6:0] character, [8:7] code_kind, [15:9] code_value
  input  logic [1:0]  in_tuser,   // [1:0] mode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [7:0] out_byte
  output logic        out_tlast,  // string_done
  output logic        out_tuser   // [0] unmapped_error
);

  localparam int unsigned IDX_W = (CHARSET_SIZE > 1) ? $clog2(CHARSET_SIZE) : 1;

  // Input fields
  logic [6:0]       character;
  logic [1:0]       code_kind;
  logic [6:0]       code_value;
  logic [1:0]       mode;
  logic [IDX_W-1:0] idx;
  logic             in_range;
  logic             accept;

  assign character  = in_tdata[6:0];
  assign code_kind  = in_tdata[8:7];
  assign code_value = in_tdata[15:9];
  assign mode       = in_tuser;
  assign idx        = IDX_W'(character);
  assign in_range   = ({2'b00, character} < 9'(CHARSET_SIZE));
  assign accept     = in_tvalid && in_tready;

  // Code table and its valid flags
  nfsp_pkg::entry_t         table_mem [CHARSET_SIZE];
  logic [CHARSET_SIZE-1:0]  tvalid_r;
  logic                     tbl_wr;

  assign tbl_wr = accept && (mode == nfsp_pkg::MODE_LOAD) && in_range;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tvalid_r <= '0;
    end else if (tbl_wr) begin
      tvalid_r[idx] <= 1'b1;
    end
  end

  // Stage register: mode, table read data and hit flag
  logic             s1_valid_r, s1_valid_nxt;
  logic [1:0]       s1_mode_r;
  logic             s1_hit_r;
  nfsp_pkg::entry_t s1_entry_r;
  logic             s1_go;
  logic             room;

  always_ff @(posedge clk) begin
    if (tbl_wr) begin
      table_mem[idx] <= '{kind: code_kind, value: code_value};
    end
    if (accept) begin
      s1_entry_r <= table_mem[idx];
      s1_hit_r   <= in_range && tvalid_r[idx];
      s1_mode_r  <= mode;
    end
  end

  assign s1_go     = s1_valid_r && room;
  assign in_tready = !s1_valid_r || room;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (accept) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_go) begin
      s1_valid_nxt = 1'b0;
    end
  end

  // Packing state
  logic       pend_r, pend_nxt;
  logic [3:0] nib_r, nib_nxt;
  nfsp_pkg::push_t  push;
  nfsp_pkg::entry_t ent;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      pend_r     <= 1'b0;
      nib_r      <= 4'd0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      if (s1_go) begin
        pend_r <= pend_nxt;
        nib_r  <= nib_nxt;
      end
    end
  end

  // Nibble merge for the staged item
  always_comb begin
    ent      = s1_hit_r ? s1_entry_r : '0;
    pend_nxt = pend_r;
    nib_nxt  = nib_r;
    push     = '0;
    case (s1_mode_r)
      nfsp_pkg::MODE_ENCODE: begin
        case (ent.kind)
          nfsp_pkg::KIND_ONE: begin
            if (!pend_r) begin
              pend_nxt = 1'b1;
              nib_nxt  = ent.value[3:0];
            end else begin
              push.cnt = 2'd1;
              push.r0  = '{out_byte: {ent.value[3:0], nib_r},
                           string_done: 1'b0, unmapped_error: 1'b0};
              pend_nxt = 1'b0;
              nib_nxt  = 4'd0;
            end
          end
          nfsp_pkg::KIND_THREE: begin
            if (!pend_r) begin
              // escape in the low nibble, code high bits above it
              push.cnt = 2'd1;
              push.r0  = '{out_byte: {1'b0, ent.value[6:4], nfsp_pkg::ESCAPE_NIBBLE},
                           string_done: 1'b0, unmapped_error: 1'b0};
              pend_nxt = 1'b1;
              nib_nxt  = ent.value[3:0];
            end else begin
              // escape completes the byte, code follows whole
              push.cnt = 2'd2;
              push.r0  = '{out_byte: {nfsp_pkg::ESCAPE_NIBBLE, nib_r},
                           string_done: 1'b0, unmapped_error: 1'b0};
              push.r1  = '{out_byte: {1'b0, ent.value},
                           string_done: 1'b0, unmapped_error: 1'b0};
              pend_nxt = 1'b0;
              nib_nxt  = 4'd0;
            end
          end
          default: begin
            push.cnt = 2'd1;
            push.r0  = '{out_byte: 8'd0, string_done: 1'b0, unmapped_error: 1'b1};
          end
        endcase
      end
      nfsp_pkg::MODE_END: begin
        if (pend_r && (nib_r != 4'd0)) begin
          push.cnt = 2'd2;
          push.r0  = '{out_byte: {4'd0, nib_r}, string_done: 1'b0, unmapped_error: 1'b0};
          push.r1  = '{out_byte: 8'd0, string_done: 1'b1, unmapped_error: 1'b0};
        end else begin
          push.cnt = 2'd1;
          push.r0  = '{out_byte: 8'd0, string_done: 1'b1, unmapped_error: 1'b0};
        end
        pend_nxt = 1'b0;
        nib_nxt  = 4'd0;
      end
      default: begin
        push.cnt = 2'd0;
      end
    endcase
    if (!s1_go) begin
      push.cnt = 2'd0;
    end
  end

  // Output queue
  nfsp_pkg::res_t head;

  nfsp_out_fifo u_out_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .room       (room),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .head       (head)
  );

  assign out_tdata = head.out_byte;
  assign out_tlast = head.string_done;
  assign out_tuser = head.unmapped_error;

endmodule

// ===== rtl/nfsp_checker.sv =====
// Port-level checker for the nibble frequency string packer, bound to the
// top level. Depends on nibble_frequency_string_packer's port list only.
module nfsp_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tvalid,
  input logic       in_tready,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic       out_tlast,
  input logic       out_tuser
);

  // Queue empties on reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // Stalled result holds its payload
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)
      && $stable(out_tlast) && $stable(out_tuser))
    else $error("stalled result changed");

  // Error results carry a zero byte and never end a string
  a_err_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata == 8'd0 && !out_tlast)
    else $error("malformed error result");

  // A string end is always a zero terminator
  a_last_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tdata == 8'd0)
    else $error("string end without zero byte");

  // Nothing reaches the output from an idle, empty start without an input transfer
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid && !(in_tvalid && in_tready) && $past(!(in_tvalid && in_tready))
      && $past(!out_tvalid) |=> !out_tvalid)
    else $error("result without a preceding transfer");

endmodule

bind nibble_frequency_string_packer nfsp_checker u_nfsp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast),
  .out_tuser  (out_tuser)
);

// ===== dv/nfsp_checker.sv =====
// Scoreboard for the nibble frequency string packer: watches both stream channels,
// tracks the code table and the nibble packing state, and compares every output transfer.
// Depends on nfsp_pkg.
module nfsp_scoreboard (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [15:0] in_tdata,   // [6:0] character, [8:7] code_kind, [15:9] code_value
  input  logic [1:0]  in_tuser,   // [1:0] mode
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [7:0]  out_tdata,  // [7:0] out_byte
  input  logic        out_tlast,  // string_done
  input  logic        out_tuser,  // [0] unmapped_error
  output int          fail_count,
  output int          outstanding
);

  nfsp_pkg::entry_t code_tab [0:127];
  logic   half_full;      // low nibble of the current byte is taken
  logic [3:0] low_nib;
  nfsp_pkg::res_t expected_bytes [$];
  int     mismatches;

  function automatic void push_byte(input logic [7:0] b, input logic done, input logic err);
    nfsp_pkg::res_t r;
    r.out_byte       = b;
    r.string_done    = done;
    r.unmapped_error = err;
    expected_bytes.insert(expected_bytes.size(), r);
  endfunction

  // Next packing step for one accepted item; queues the bytes it yields
  task automatic pack_char_item(input logic [1:0] md, input logic [15:0] dat);
    logic [6:0]       ch;
    nfsp_pkg::entry_t ent;
    ch = dat[6:0];
    case (md)
      nfsp_pkg::MODE_LOAD: begin
        code_tab[ch].kind  = dat[8:7];
        code_tab[ch].value = dat[15:9];
      end
      nfsp_pkg::MODE_ENCODE: begin
        ent = code_tab[ch];
        if (ent.kind == nfsp_pkg::KIND_ONE) begin
          if (!half_full) begin
            half_full = 1'b1;
            low_nib   = ent.value[3:0];
          end else begin
            push_byte({ent.value[3:0], low_nib}, 1'b0, 1'b0);
            half_full = 1'b0;
            low_nib   = 4'h0;
          end
        end else if (ent.kind == nfsp_pkg::KIND_THREE) begin
          if (!half_full) begin
            // escape fills the low nibble, code's top half the high one
            push_byte({1'b0, ent.value[6:4], nfsp_pkg::ESCAPE_NIBBLE}, 1'b0, 1'b0);
            half_full = 1'b1;
            low_nib   = ent.value[3:0];
          end else begin
            push_byte({nfsp_pkg::ESCAPE_NIBBLE, low_nib}, 1'b0, 1'b0);
            push_byte({1'b0, ent.value}, 1'b0, 1'b0);
            half_full = 1'b0;
            low_nib   = 4'h0;
          end
        end else begin
          // no code, or the unused kind: error result, state untouched
          push_byte(8'h00, 1'b0, 1'b1);
        end
      end
      nfsp_pkg::MODE_END: begin
        if (half_full && low_nib != 4'h0)
          push_byte({4'h0, low_nib}, 1'b0, 1'b0);
        push_byte(8'h00, 1'b1, 1'b0);
        half_full = 1'b0;
        low_nib   = 4'h0;
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    nfsp_pkg::res_t want;
    if (!rst_n) begin
      for (int i = 0; i < 128; i++) code_tab[i] = '0;
      half_full = 1'b0;
      low_nib   = 4'h0;
      expected_bytes.delete();
      mismatches = 0;
    end else begin
      if (in_tvalid && in_tready)
        pack_char_item(in_tuser, in_tdata);
      // compare output transfer against the oldest expectation
      if (out_tvalid && out_tready) begin
        if (expected_bytes.size() == 0) begin
          $error("unexpected output transfer: out_byte %02h", out_tdata);
          mismatches++;
        end else begin
          want = expected_bytes.pop_front();
          if (out_tdata !== want.out_byte) begin
            $error("out_byte: expected %02h, got %02h", want.out_byte, out_tdata);
            mismatches++;
          end
          if (out_tlast !== want.string_done) begin
            $error("string_done: expected %0b, got %0b", want.string_done, out_tlast);
            mismatches++;
          end
          if (out_tuser !== want.unmapped_error) begin
            $error("unmapped_error: expected %0b, got %0b", want.unmapped_error, out_tuser);
            mismatches++;
          end
        end
      end
    end
    fail_count  <= mismatches;
    outstanding <= expected_bytes.size();
  end

endmodule

// ===== dv/tb_top.sv =====
// Testbench top for the nibble frequency string packer: clock, reset, stimulus,
// output back-pressure, idle watchdog and verdict. Depends on nfsp_pkg,
// nibble_frequency_string_packer and nfsp_scoreboard.
module tb_top;

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int ITEM_TARGET = 1750;
  localparam int LONG_HOLD   = 400;
  localparam int IDLE_LIMIT  = 3000;
  localparam int DRAIN_EXTRA = 8;
  // receiver stall styles
  localparam int RX_ALWAYS = 0;
  localparam int RX_HALF   = 1;
  localparam int RX_SPARSE = 2;
  localparam int RX_MOSTLY = 3;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;   // [6:0] character, [8:7] code_kind, [15:9] code_value
  logic [1:0]  in_tuser;   // [1:0] mode
  logic        out_tvalid;
  logic        out_tready;
  logic [7:0]  out_tdata;  // [7:0] out_byte
  logic        out_tlast;  // string_done
  logic        out_tuser;  // [0] unmapped_error
  int          fail_count;
  int          outstanding;

  int burst_left;
  int items_sent;
  int idle_cycles;
  bit long_hold_req;

  nibble_frequency_string_packer dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  nfsp_scoreboard u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .out_tuser   (out_tuser),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Watchdog: cycles without any transfer on either channel
  always @(posedge clk) begin
    if (!rst_n) begin
      idle_cycles <= 0;
    end else if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == IDLE_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  // Receiver: stretches of different stall styles, one long hold on request
  initial begin
    int stretch;
    int style;
    out_tready <= 1'b0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else begin
        stretch = $urandom_range(8, 60);
        style   = $urandom_range(RX_ALWAYS, RX_MOSTLY);
        repeat (stretch) begin
          case (style)
            RX_ALWAYS: out_tready <= 1'b1;
            RX_HALF:   out_tready <= ($urandom_range(0, 1) == 1);
            RX_SPARSE: out_tready <= ($urandom_range(0, 3) == 0);
            default:   out_tready <= ($urandom_range(0, 7) != 0);
          endcase
          @(posedge clk);
        end
      end
    end
  end

  function automatic logic [15:0] item_fields(input logic [6:0] ch, input logic [1:0] knd,
                                              input logic [6:0] val);
    return {val, knd, ch};
  endfunction

  // Random table entry, mostly valid codes, some unmapped or unused kind
  function automatic logic [15:0] random_entry(input logic [6:0] ch);
    int roll;
    logic [1:0] knd;
    logic [6:0] val;
    roll = $urandom_range(0, 99);
    val  = 7'($urandom_range(0, 127));
    if (roll < 45) begin
      knd = nfsp_pkg::KIND_ONE;
      if ($urandom_range(0, 9) != 0) val = 7'($urandom_range(1, 14));
    end else if (roll < 87) begin
      knd = nfsp_pkg::KIND_THREE;
    end else if (roll < 95) begin
      knd = nfsp_pkg::KIND_NONE;
    end else begin
      knd = KIND_UNUSED;
    end
    return item_fields(ch, knd, val);
  endfunction

  function automatic logic [15:0] noise_fields(input logic [6:0] ch);
    return item_fields(ch, 2'($urandom_range(0, 3)), 7'($urandom_range(0, 127)));
  endfunction

  // Offer one item in bursts with random gaps; returns after its transfer
  task automatic send_item(input logic [1:0] md, input logic [15:0] dat);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata  <= dat;
    in_tuser  <= md;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    items_sent++;
  endtask

  // Stop offering until every expected byte has come out
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_EXTRA) @(posedge clk);
    burst_left = 0;
  endtask

  initial begin
    int  pick;
    int  len;
    bit  drained_once;
    bit  held_once;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= nfsp_pkg::MODE_LOAD;
    rst_n     <= 1'b0;
    burst_left    = 0;
    items_sent    = 0;
    long_hold_req = 1'b0;
    drained_once  = 1'b0;
    held_once     = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: table after reset, field extremes, all kinds and modes
    send_item(nfsp_pkg::MODE_ENCODE, item_fields(7'd65, nfsp_pkg::KIND_NONE, 7'd0)); // empty table
    send_item(nfsp_pkg::MODE_LOAD,   item_fields(7'd0, nfsp_pkg::KIND_ONE, 7'd0));
    send_item(nfsp_pkg::MODE_LOAD,   item_fields(7'd127, nfsp_pkg::KIND_ONE, 7'd14));
    // out of range nibble
    send_item(nfsp_pkg::MODE_LOAD,   item_fields(7'd5, nfsp_pkg::KIND_ONE, 7'd127));
    send_item(nfsp_pkg::MODE_LOAD,   item_fields(7'd1, nfsp_pkg::KIND_THREE, 7'd127));
    send_item(nfsp_pkg::MODE_LOAD,   item_fields(7'd2, nfsp_pkg::KIND_THREE, 7'd0));
    send_item(nfsp_pkg::MODE_LOAD,   item_fields(7'd3, KIND_UNUSED, 7'd85));
    send_item(MODE_UNUSED, 16'hFFFF);                                  // ignored mode
    send_item(nfsp_pkg::MODE_ENCODE, item_fields(7'd127, nfsp_pkg::KIND_NONE, 7'd0));
    // escape in high nibble
    send_item(nfsp_pkg::MODE_ENCODE, item_fields(7'd1, nfsp_pkg::KIND_NONE, 7'd0));
    send_item(nfsp_pkg::MODE_ENCODE, item_fields(7'd0, nfsp_pkg::KIND_NONE, 7'd0));
    send_item(nfsp_pkg::MODE_ENCODE, item_fields(7'd2, nfsp_pkg::KIND_NONE, 7'd0));
    // unused kind
    send_item(nfsp_pkg::MODE_ENCODE, item_fields(7'd3, nfsp_pkg::KIND_NONE, 7'd0));
    // nothing pending
    send_item(nfsp_pkg::MODE_END,    item_fields(7'd0, nfsp_pkg::KIND_NONE, 7'd0));
    // escape in low nibble
    send_item(nfsp_pkg::MODE_ENCODE, item_fields(7'd1, nfsp_pkg::KIND_NONE, 7'd0));
    // nonzero pending
    send_item(nfsp_pkg::MODE_END,    item_fields(7'd127, KIND_UNUSED, 7'd127));
    send_item(nfsp_pkg::MODE_ENCODE, item_fields(7'd0, nfsp_pkg::KIND_NONE, 7'd0));
    // zero pending
    send_item(nfsp_pkg::MODE_END,    item_fields(7'd0, nfsp_pkg::KIND_NONE, 7'd0));
    send_item(nfsp_pkg::MODE_ENCODE, item_fields(7'd5, nfsp_pkg::KIND_NONE, 7'd0));
    send_item(nfsp_pkg::MODE_ENCODE, item_fields(7'd127, nfsp_pkg::KIND_NONE, 7'd0));
    send_item(nfsp_pkg::MODE_END,    item_fields(7'd0, nfsp_pkg::KIND_NONE, 7'd0));
    // unmap again
    send_item(nfsp_pkg::MODE_LOAD,   item_fields(7'd1, nfsp_pkg::KIND_NONE, 7'd0));
    send_item(nfsp_pkg::MODE_ENCODE, item_fields(7'd1, nfsp_pkg::KIND_NONE, 7'd0));
    // empty string
    send_item(nfsp_pkg::MODE_END,    item_fields(7'd0, nfsp_pkg::KIND_NONE, 7'd0));
    wait_drained();

    // Fill the whole table, then random strings
    for (int c = 0; c < 128; c++) send_item(nfsp_pkg::MODE_LOAD, random_entry(c[6:0]));
    while (items_sent < ITEM_TARGET) begin
      if (!drained_once && items_sent > 500) begin
        drained_once = 1'b1;
        wait_drained();
      end
      if (!held_once && items_sent > 900) begin
        // receiver stalls long while the sender keeps offering
        held_once     = 1'b1;
        long_hold_req = 1'b1;
        burst_left    = 100;
      end
      pick = $urandom_range(0, 99);
      if (pick < 82) begin
        len = $urandom_range(0, 10);
        repeat (len) begin
          if ($urandom_range(0, 19) == 0)
            send_item(nfsp_pkg::MODE_LOAD, random_entry(7'($urandom_range(0, 127))));
          send_item(nfsp_pkg::MODE_ENCODE, noise_fields(7'($urandom_range(0, 127))));
        end
        send_item(nfsp_pkg::MODE_END, noise_fields(7'($urandom_range(0, 127))));
      end else if (pick < 90) begin
        send_item(nfsp_pkg::MODE_LOAD, random_entry(7'($urandom_range(0, 127))));
      end else if (pick < 95) begin
        send_item(MODE_UNUSED, noise_fields(7'($urandom_range(0, 127))));
      end else begin
        send_item(nfsp_pkg::MODE_END, noise_fields(7'($urandom_range(0, 127))));
      end
    end

    wait_drained();
    if (fail_count == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
